// ===== hw/rtl/rdsc_pkg.sv =====
// shared types, constants and digit helpers for the radix digit string converter
package rdsc_pkg;

   localparam int RADIX_W       = 6;
   localparam int CHAR_W        = 7;
   localparam int BITS_PER_STEP = 4;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] DEC_LIMIT   = 6'd9;
   localparam logic [CHAR_W-1:0]  ALPHA_BASE  = 7'd64;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // saturate the programmed base into the supported range
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      if (r < RADIX_MIN) begin
         return RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return r;
   endfunction

   // digit value to ascii, decimal digits then uppercase letters
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d > DEC_LIMIT) begin
         return d_ext - {1'b0, DEC_LIMIT} + ALPHA_BASE;
      end
      return ASCII_ZERO + d_ext;
   endfunction

endpackage

// ===== hw/rtl/rdsc_req_if.sv =====
// request channel carrying one value to convert
interface rdsc_req_if #(parameter int VALUE_WIDTH = 31) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source(output valid, output value, input ready);
   modport sink(input valid, input value, output ready);
endinterface

// ===== hw/rtl/rdsc_rsp_if.sv =====
// response channel carrying one ascii digit per beat
interface rdsc_rsp_if import rdsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last_digit;

   modport source(output valid, output digit_char, output last_digit, input ready);
   modport sink(input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== hw/rtl/radix_digit_string_converter_core.sv =====
// radix digit string converter top level: front end, queue, divider back end
// order: queue pop, divider, buffer read, output register; the divider works out every digit
// before the first character is read
// the divider shares one 4-bit-per-cycle subtract slice and takes a new value only
// after the previous value's last digit is issued; the queue takes two values meanwhile
// reset: synchronous, radix returns to 10, queue and sequencer empty, buffer not cleared
module radix_digit_string_converter_core import rdsc_pkg::*; #(
   parameter int VALUE_WIDTH = 31,
   parameter int DIGIT_SLOTS = 32
) (
   input  logic               clock,
   input  logic               reset,
   rdsc_req_if.sink           req_ch,
   rdsc_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [RADIX_W-1:0] csr_wr_data
);

   localparam int ENTRY_W = VALUE_WIDTH + RADIX_W;

   queue_status_type   q_status;
   logic               push_valid;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;

   rdsc_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rdsc_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   rdsc_back #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DIGIT_SLOTS(DIGIT_SLOTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_status(q_status),
      .pop     (pop),
      .pop_data(pop_data),
      .rsp_ch  (rsp_ch)
   );

   // back end only pops a filled queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // front end never pushes into a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("push into full queue");

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid after reset");

   // every emitted character is a digit or an uppercase letter
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.digit_char >= 7'd48) && (rsp_ch.digit_char <= 7'd57)) ||
                       ((rsp_ch.digit_char >= 7'd65) && (rsp_ch.digit_char <= 7'd90)))
      else $error("digit character out of range");

endmodule

// ===== hw/rtl/rdsc_front.sv =====
// front end: radix register, request intake and queue push
module rdsc_front import rdsc_pkg::*; #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   rdsc_req_if.sink                       req_ch,
   input  logic                           csr_wr_en,
   input  logic [RADIX_W-1:0]             csr_wr_data,
   input  queue_status_type               q_status,
   output logic                           push_valid,
   output logic [VALUE_WIDTH+RADIX_W-1:0] push_data
);

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;

   // radix register
   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en) begin
         radix_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // each beat is tagged with its saturated base
   assign req_ch.ready = !q_status.full;
   assign push_valid   = req_ch.valid && !q_status.full;
   assign push_data    = {req_ch.value, clamp_radix(radix_ff)};

endmodule

// ===== hw/rtl/rdsc_queue.sv =====
// short fifo between front and back ends
module rdsc_queue import rdsc_pkg::*; #(
   parameter int WIDTH = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (level_ff == LVL_W'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/rdsc_back.sv =====
// back end: iterative divider, digit buffer and most-significant-first emitter
module rdsc_back import rdsc_pkg::*; #(
   parameter int VALUE_WIDTH = 31,
   parameter int DIGIT_SLOTS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  queue_status_type               q_status,
   output logic                           pop,
   input  logic [VALUE_WIDTH+RADIX_W-1:0] pop_data,
   rdsc_rsp_if.source                     rsp_ch
);

   localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int WORK_W = STEPS * BITS_PER_STEP;
   localparam int STEP_W = $clog2(STEPS);
   localparam int CNT_W  = $clog2(DIGIT_SLOTS + 1);
   localparam int ADDR_W = $clog2(DIGIT_SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [WORK_W-1:0]  work_ff, work_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_last_ff, rd_last_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;

   logic [RADIX_W-1:0] digit_mem [DIGIT_SLOTS];
   logic [RADIX_W-1:0] rd_data_ff;

   logic [WORK_W-1:0]  div_work;
   logic [RADIX_W-1:0] div_rem;
   logic [RADIX_W:0]   div_part;
   logic               digit_done;
   logic               move;
   logic               issue;
   logic [ADDR_W-1:0]  rd_addr;

   // restoring division, BITS_PER_STEP quotient bits per cycle
   always_comb begin
      div_rem  = rem_ff;
      div_work = work_ff;
      div_part = '0;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         div_part = {div_rem, div_work[WORK_W-1]};
         div_work = {div_work[WORK_W-2:0], 1'b0};
         if (div_part >= {1'b0, radix_ff}) begin
            div_part    = div_part - {1'b0, radix_ff};
            div_work[0] = 1'b1;
         end
         div_rem = div_part[RADIX_W-1:0];
      end
   end

   assign digit_done = (state_ff == ST_DIV) && (step_ff == STEP_W'(STEPS - 1));
   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;
   assign move       = rd_pend_ff && (!out_valid_ff || rsp_ch.ready);
   assign issue      = (state_ff == ST_EMIT) && (idx_ff != '0) && (!rd_pend_ff || move);
   assign rd_addr    = ADDR_W'(idx_ff - CNT_W'(1));

   // sequencer and output pipeline next state
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      radix_in     = radix_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               work_in  = WORK_W'(pop_data[VALUE_WIDTH+RADIX_W-1:RADIX_W]);
               radix_in = pop_data[RADIX_W-1:0];
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = div_work;
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
            if (digit_done) begin
               step_in  = '0;
               rem_in   = '0;
               count_in = count_ff + CNT_W'(1);
               if ((div_work == '0) || (count_ff == CNT_W'(DIGIT_SLOTS - 1))) begin
                  idx_in   = count_ff + CNT_W'(1);
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               idx_in = idx_ff - CNT_W'(1);
               if (idx_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // buffer read stage
      if (move) begin
         rd_pend_in = 1'b0;
      end
      if (issue) begin
         rd_pend_in = 1'b1;
         rd_last_in = (idx_ff == CNT_W'(1));
      end

      // output register
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_valid_in = 1'b1;
         out_char_in  = digit_to_ascii(rd_data_ff);
         out_last_in  = rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      work_ff     <= work_in;
      radix_ff    <= radix_in;
      rem_ff      <= rem_in;
      rd_last_ff  <= rd_last_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // digit buffer, written per finished digit, read one slot a cycle unless the output stalls
   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_mem[count_ff[ADDR_W-1:0]] <= div_rem;
      end
      if (issue) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.digit_char = out_char_ff;
   assign rsp_ch.last_digit = out_last_ff;

endmodule
